// ----- hw/rtl/mqd_pkg.sv -----
`default_nettype none

package mqd_pkg;

	// Default build parameters
	localparam int DEF_MAX_ENCODERS = 4;
	localparam int DEF_COUNT_WIDTH  = 32;

	// Fixed field widths
	localparam int POS_W   = 32;
	localparam int CFG_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Item operation codes
	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_SET    = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// Detent latch modes; LATCH_NONE disables detent updates and position loads
	typedef enum logic [1:0] {
		LATCH_AT3  = 2'd0,
		LATCH_AT0  = 2'd1,
		LATCH_TWO  = 2'd2,
		LATCH_NONE = 2'd3
	} latch_t;

	// Rotation direction codes
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENC_COUNT  = 2'd0,
		CFG_LATCH_MODE = 2'd1,
		CFG_BUTTON0    = 2'd2,
		CFG_BUTTON1    = 2'd3
	} cfg_idx_t;

	// Count step from the Gray transition table
	typedef enum logic [1:0] {
		STEP_HOLD = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// Per-item control, one per lane; sel, active and pair differ by lane
	typedef struct packed {
		logic   accept;
		mode_t  mode;
		latch_t latch;
		logic   active;
		logic   sel;
		logic [1:0] pair;
	} lane_ctrl_t;

	// One result word
	typedef struct packed {
		logic signed [POS_W-1:0] position;
		dir_t                    direction;
		logic                    button0;
		logic                    button1;
	} out_word_t;

	// Transition table indexed by {previous pair, new pair}
	function automatic step_t gray_step(input logic [3:0] trans);
		step_t s;
		case (trans)
			4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
			4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
			default:                  s = STEP_HOLD;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mqd_lane.sv -----
`default_nettype none

module mqd_lane #(
	parameter int COUNT_WIDTH = mqd_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mqd_pkg::lane_ctrl_t           ctrl,
	input  wire logic signed [mqd_pkg::POS_W-1:0] new_position,
	output logic signed [COUNT_WIDTH-1:0]      det_pos,
	output mqd_pkg::dir_t                      dir
);
	import mqd_pkg::*;

	logic [1:0]                    last_pair_q;
	logic [COUNT_WIDTH-1:0]        raw_q;
	logic signed [COUNT_WIDTH-1:0] det_q;
	logic signed [COUNT_WIDTH-1:0] lread_q;

	logic [1:0]                    last_pair_d;
	logic [COUNT_WIDTH-1:0]        raw_d;
	logic signed [COUNT_WIDTH-1:0] det_d;
	logic signed [COUNT_WIDTH-1:0] lread_d;
	logic [COUNT_WIDTH-1:0]        raw_step;
	logic signed [COUNT_WIDTH-1:0] np_cw;
	logic                          changed;
	logic                          latch_hit;
	step_t                         step;

	// New position, sign-extended or truncated to count width
	assign np_cw = COUNT_WIDTH'(new_position);

	// Sample path: table step and detent detect
	assign changed = ctrl.pair != last_pair_q;
	assign step    = gray_step({last_pair_q, ctrl.pair});

	always_comb begin
		case (step)
			STEP_UP:   raw_step = raw_q + COUNT_WIDTH'(1);
			STEP_DOWN: raw_step = raw_q - COUNT_WIDTH'(1);
			default:   raw_step = raw_q;
		endcase
	end

	always_comb begin
		case (ctrl.latch)
			LATCH_AT3: latch_hit = changed && ctrl.pair == 2'd3;
			LATCH_AT0: latch_hit = changed && ctrl.pair == 2'd0;
			LATCH_TWO: latch_hit = changed && (ctrl.pair == 2'd0 || ctrl.pair == 2'd3);
			default:   latch_hit = 1'b0;
		endcase
	end

	// Readout seen by the merge stage
	assign det_pos = det_q;
	always_comb begin
		if (det_q < lread_q)
			dir = DIR_CCW;
		else if (lread_q < det_q)
			dir = DIR_CW;
		else
			dir = DIR_NONE;
	end

	// Next state per operation
	always_comb begin
		last_pair_d = last_pair_q;
		raw_d       = raw_q;
		det_d       = det_q;
		lread_d     = lread_q;
		unique case (ctrl.mode)
			MODE_SAMPLE: begin
				if (ctrl.active) begin
					last_pair_d = ctrl.pair;
					raw_d       = raw_step;
					if (latch_hit) begin
						if (ctrl.latch == LATCH_TWO)
							det_d = $signed(raw_step) >>> 1;
						else
							det_d = $signed(raw_step) >>> 2;
					end
				end
			end
			MODE_SET: begin
				if (ctrl.sel && ctrl.latch != LATCH_NONE) begin
					if (ctrl.latch == LATCH_TWO)
						raw_d = {np_cw[COUNT_WIDTH-2:0], raw_q[0]};
					else
						raw_d = {np_cw[COUNT_WIDTH-3:0], raw_q[1:0]};
					det_d   = np_cw;
					lread_d = np_cw;
				end
			end
			MODE_CLEAR: begin
				if (ctrl.sel) begin
					last_pair_d = 2'd3;
					raw_d       = '0;
					det_d       = '0;
					lread_d     = '0;
				end
			end
			MODE_READ: begin
				if (ctrl.sel)
					lread_d = det_q;
			end
			default: ;
		endcase
	end

	// Lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pair_q <= 2'd3;
			raw_q       <= '0;
			det_q       <= '0;
			lread_q     <= '0;
		end else if (ctrl.accept) begin
			last_pair_q <= last_pair_d;
			raw_q       <= raw_d;
			det_q       <= det_d;
			lread_q     <= lread_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mqd_outbuf.sv -----
`default_nettype none

module mqd_outbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mqd_pkg::out_word_t push_word,
	output logic                    can_push,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mqd_pkg::out_word_t      out_word
);
	import mqd_pkg::*;

	logic      main_v_q;
	logic      skid_v_q;
	out_word_t main_q;
	out_word_t skid_q;
	logic      pop;

	assign pop       = main_v_q && out_ready;
	assign can_push  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_word  = main_q;

	// Valid flags: main register plus one skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload moves
	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push)
					skid_q <= push_word;
			end else if (push) begin
				main_q <= push_word;
			end
		end else if (push) begin
			skid_q <= push_word;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_quadrature_decoder.sv -----
`default_nettype none
// Channel  | Handshake               | Word
// ---------+-------------------------+--------------------------------------------------
// input    | in_valid / in_ready     | mode, port_sample, encoder_index, new_position
// output   | out_valid / out_ready   | position, direction, button0/1_pressed
// config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// One word per cycle sustained while out_ready is high; every lane updates in the
// accept cycle and the result is registered into the output register or skid word.
// A skid word behind the output register takes one result while the output stalls;
// in_ready drops only while both output words are held.
// arst_n resets lanes plus config, button and valid registers at once; no sweep.

module multi_quadrature_decoder #(
	parameter int MAX_ENCODERS = mqd_pkg::DEF_MAX_ENCODERS,
	parameter int COUNT_WIDTH  = mqd_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         mode,
	input  wire logic [7:0]                         port_sample,
	input  wire logic [2:0]                         encoder_index,
	input  wire logic signed [mqd_pkg::POS_W-1:0]   new_position,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [mqd_pkg::POS_W-1:0]        position,
	output logic [1:0]                              direction,
	output logic                                    button0_pressed,
	output logic                                    button1_pressed,
	input  wire logic                               cfg_we,
	input  wire logic [mqd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mqd_pkg::CFG_W-1:0]          cfg_data
);
	import mqd_pkg::*;

	logic [2:0] enc_count_q;
	latch_t     latch_q;
	logic [3:0] btn0_bit_q;
	logic [3:0] btn1_bit_q;
	logic       btn0_q;
	logic       btn1_q;
	logic       btn0_d;
	logic       btn1_d;

	logic       accept;
	logic       idx_ok;
	mode_t      mode_w;
	lane_ctrl_t ctrl [MAX_ENCODERS];
	logic signed [COUNT_WIDTH-1:0] lane_pos [MAX_ENCODERS];
	dir_t       lane_dir [MAX_ENCODERS];
	logic signed [COUNT_WIDTH-1:0] sel_pos;
	dir_t       sel_dir;
	out_word_t  res_word;
	out_word_t  out_word;

	assign accept = in_valid && in_ready;
	assign mode_w = mode_t'(mode);
	assign idx_ok = encoder_index < enc_count_q && encoder_index < 3'(MAX_ENCODERS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_count_q <= 3'd4;
			latch_q     <= LATCH_AT3;
			btn0_bit_q  <= 4'd8;
			btn1_bit_q  <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENC_COUNT:  enc_count_q <= cfg_data[2:0];
				CFG_LATCH_MODE: latch_q     <= latch_t'(cfg_data[1:0]);
				CFG_BUTTON0:    btn0_bit_q  <= cfg_data;
				CFG_BUTTON1:    btn1_bit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Buttons, active low, sampled from the full byte
	always_comb begin
		btn0_d = btn0_q;
		btn1_d = btn1_q;
		if (mode_w == MODE_SAMPLE) begin
			if (!btn0_bit_q[3])
				btn0_d = !port_sample[btn0_bit_q[2:0]];
			if (!btn1_bit_q[3])
				btn1_d = !port_sample[btn1_bit_q[2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn0_q <= 1'b0;
			btn1_q <= 1'b0;
		end else if (accept) begin
			btn0_q <= btn0_d;
			btn1_q <= btn1_d;
		end
	end

	// Encoder lanes; only the low nibble carries pairs
	for (genvar i = 0; i < MAX_ENCODERS; i++) begin : g_lane
		always_comb begin
			ctrl[i].accept = accept;
			ctrl[i].mode   = mode_w;
			ctrl[i].latch  = latch_q;
			ctrl[i].active = enc_count_q > 3'(i);
			ctrl[i].sel    = idx_ok && encoder_index == 3'(i);
			if (i < 2)
				ctrl[i].pair = port_sample[2*i +: 2];
			else
				ctrl[i].pair = 2'd0;
		end

		mqd_lane #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl[i]),
			.new_position (new_position),
			.det_pos      (lane_pos[i]),
			.dir          (lane_dir[i])
		);
	end

	// Merge: pick the addressed lane's readout
	always_comb begin
		sel_pos = '0;
		sel_dir = DIR_NONE;
		for (int i = 0; i < MAX_ENCODERS; i++) begin
			if (encoder_index == 3'(i)) begin
				sel_pos = lane_pos[i];
				sel_dir = lane_dir[i];
			end
		end
	end

	always_comb begin
		res_word.position  = '0;
		res_word.direction = DIR_NONE;
		res_word.button0   = btn0_d;
		res_word.button1   = btn1_d;
		if (mode_w == MODE_READ) begin
			if (idx_ok) begin
				res_word.position  = POS_W'(sel_pos);
				res_word.direction = sel_dir;
			end else begin
				res_word.position  = '1;
			end
		end
	end

	// Output register with skid word
	mqd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (res_word),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign position        = out_word.position;
	assign direction       = out_word.direction;
	assign button0_pressed = out_word.button0;
	assign button1_pressed = out_word.button1;

endmodule

`default_nettype wire

// ----- hw/rtl/mqd_chk.sv -----
`default_nettype none

module mqd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] position,
	input wire logic [1:0]  direction
);

	// Held result stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(direction))
		else $error("output word changed while stalled");

	// An accepted word always leaves out_valid set in the next cycle
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word missing at output");

	// Backpressure only while results are pending
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// Direction code never takes the unused value
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction != 2'd3)
		else $error("illegal direction code");

endmodule

bind multi_quadrature_decoder mqd_chk u_mqd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.position  (position),
	.direction (direction)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import mqd_pkg::*;

	localparam int NUM_LANES   = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_WORDS = 200;
	localparam int MAX_PRINTS  = 40;

	// Count delta per transition, indexed by {previous pair, new pair}
	localparam int GRAY_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
	// Next pair when turning clockwise / counterclockwise
	localparam logic [1:0] CW_NEXT  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [1:0] CCW_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [7:0] port_sample;
	logic [2:0] encoder_index;
	logic signed [POS_W-1:0] new_position;
	logic out_valid;
	logic out_ready;
	logic signed [POS_W-1:0] position;
	logic [1:0] direction;
	logic button0_pressed;
	logic button1_pressed;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	multi_quadrature_decoder u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.port_sample     (port_sample),
		.encoder_index   (encoder_index),
		.new_position    (new_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.position        (position),
		.direction       (direction),
		.button0_pressed (button0_pressed),
		.button1_pressed (button1_pressed),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Decoder shadow state and register copies
	logic [2:0] enc_count;
	latch_t     latch_sel;
	logic [3:0] btn0_bit;
	logic [3:0] btn1_bit;
	logic [1:0]              prev_pair   [NUM_LANES];
	logic signed [POS_W-1:0] raw_cnt     [NUM_LANES];
	logic signed [POS_W-1:0] detent_pos  [NUM_LANES];
	logic signed [POS_W-1:0] last_read   [NUM_LANES];
	logic                    btn_held    [2];

	out_word_t expected_words[$];
	out_word_t want;

	// Stimulus bookkeeping
	logic [3:0] lane_pairs;
	int tx_gap_max;
	int rx_stall_max;
	int rx_hold_req;
	int words_sent;
	int words_checked;
	int rotation_reads;
	int settings_run;
	int errors;
	int cycle_count;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int active_encoders();
		return (enc_count > NUM_LANES) ? NUM_LANES : int'(enc_count);
	endfunction

	function automatic void reset_shadow();
		enc_count = 3'd4;
		latch_sel = LATCH_AT3;
		btn0_bit  = 4'd8;
		btn1_bit  = 4'd8;
		for (int i = 0; i < NUM_LANES; i++) begin
			prev_pair[i]  = 2'd3;
			raw_cnt[i]    = '0;
			detent_pos[i] = '0;
			last_read[i]  = '0;
		end
		btn_held[0] = 1'b0;
		btn_held[1] = 1'b0;
	endfunction

	// Applies one accepted word to the shadow state; returns the word the block must emit
	function automatic out_word_t decode_step(mode_t m, logic [7:0] p, logic [2:0] ix,
			logic signed [POS_W-1:0] np);
		out_word_t w;
		int n;
		int d;
		logic ok;
		logic [7:0] nib;
		logic [1:0] pr;
		n   = active_encoders();
		ok  = (int'(ix) < n);
		nib = {4'h0, p[3:0]};
		w   = '0;
		w.direction = DIR_NONE;
		case (m)
			MODE_SAMPLE: begin
				// buttons are active low, bit 8 and up means none
				if (btn0_bit < 4'd8)
					btn_held[0] = ~p[btn0_bit[2:0]];
				if (btn1_bit < 4'd8)
					btn_held[1] = ~p[btn1_bit[2:0]];
				for (int i = 0; i < NUM_LANES; i++) begin
					pr = nib[2*i +: 2];
					if (i < n && pr != prev_pair[i]) begin
						d = GRAY_DELTA[{prev_pair[i], pr}];
						if (d > 0)
							raw_cnt[i] = raw_cnt[i] + 1;
						else if (d < 0)
							raw_cnt[i] = raw_cnt[i] - 1;
						prev_pair[i] = pr;
						if ((latch_sel == LATCH_AT3 && pr == 2'd3) ||
								(latch_sel == LATCH_AT0 && pr == 2'd0))
							detent_pos[i] = raw_cnt[i] >>> 2;
						else if (latch_sel == LATCH_TWO && (pr == 2'd0 || pr == 2'd3))
							detent_pos[i] = raw_cnt[i] >>> 1;
					end
				end
			end
			MODE_SET: begin
				// low count bits survive a position load
				if (ok && latch_sel != LATCH_NONE) begin
					if (latch_sel == LATCH_TWO)
						raw_cnt[ix] = {np[POS_W-2:0], raw_cnt[ix][0]};
					else
						raw_cnt[ix] = {np[POS_W-3:0], raw_cnt[ix][1:0]};
					detent_pos[ix] = np;
					last_read[ix]  = np;
				end
			end
			MODE_CLEAR: begin
				if (ok) begin
					prev_pair[ix]  = 2'd3;
					raw_cnt[ix]    = '0;
					detent_pos[ix] = '0;
					last_read[ix]  = '0;
				end
			end
			MODE_READ: begin
				if (ok) begin
					w.position = detent_pos[ix];
					if (detent_pos[ix] < last_read[ix])
						w.direction = DIR_CCW;
					else if (detent_pos[ix] > last_read[ix])
						w.direction = DIR_CW;
					if (w.direction != DIR_NONE)
						rotation_reads++;
					last_read[ix] = detent_pos[ix];
				end else begin
					w.position = -1;
				end
			end
		endcase
		w.button0 = btn_held[0];
		w.button1 = btn_held[1];
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at word %0d, %s: got %0d, expected %0d",
				words_checked, what, got, exp_val);
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with none pending", 0, 0);
			end else begin
				want = expected_words.pop_front();
				if (position !== want.position)
					report_mismatch("position", longint'(position),
						longint'(want.position));
				if (direction !== want.direction)
					report_mismatch("direction", longint'(direction),
						longint'(want.direction));
				if (button0_pressed !== want.button0)
					report_mismatch("button0_pressed", longint'(button0_pressed),
						longint'(want.button0));
				if (button1_pressed !== want.button1)
					report_mismatch("button1_pressed", longint'(button1_pressed),
						longint'(want.button1));
			end
			words_checked++;
		end
	end

	// Receiver: random stall per word, plus an occasional long hold-off
	initial begin : receiver
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = $urandom_range(0, rx_stall_max);
			if (rx_hold_req > 0) begin
				wait_cycles = rx_hold_req;
				rx_hold_req = 0;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one word; returns at the edge where it is accepted
	task automatic send_word(input mode_t m, input logic [7:0] p, input logic [2:0] ix,
			input logic signed [POS_W-1:0] np);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		port_sample   <= p;
		encoder_index <= ix;
		new_position  <= np;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(decode_step(m, p, ix, np));
		words_sent++;
	endtask

	task automatic sample_port(input logic [7:0] p);
		send_word(MODE_SAMPLE, p, 3'd0, '0);
	endtask

	task automatic read_position(input logic [2:0] ix);
		send_word(MODE_READ, 8'h00, ix, '0);
	endtask

	// Sender pause: drop valid and wait out every pending word
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t r, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		case (r)
			CFG_ENC_COUNT:  enc_count = v[2:0];
			CFG_LATCH_MODE: latch_sel = latch_t'(v[1:0]);
			CFG_BUTTON0:    btn0_bit  = v;
			CFG_BUTTON1:    btn1_bit  = v;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly legal Gray walks on both decoded lanes, with reads, loads and clears mixed in
	task automatic send_random_word();
		int r;
		int n;
		int s;
		logic [1:0] pr;
		logic [2:0] ix;
		logic signed [POS_W-1:0] np;
		logic [7:0] p;
		mode_t m;
		r = $urandom_range(0, 99);
		n = active_encoders();
		if (n > 0 && $urandom_range(0, 4) != 0)
			ix = 3'($urandom_range(0, n - 1));
		else
			ix = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 5))
			0: np = 32'sh7FFF_FFFF;
			1: np = 32'sh8000_0000;
			2: np = -1;
			3: np = $urandom_range(0, 15) - 8;
			default: np = $urandom;
		endcase
		if (r < 62) begin
			m = MODE_SAMPLE;
			for (int lane = 0; lane < 2; lane++) begin
				s  = $urandom_range(0, 2);
				pr = lane_pairs[2*lane +: 2];
				if (s == 1)
					pr = CW_NEXT[pr];
				else if (s == 2)
					pr = CCW_NEXT[pr];
				lane_pairs[2*lane +: 2] = pr;
			end
			// occasional contact bounce: arbitrary jump
			if ($urandom_range(0, 19) == 0)
				lane_pairs = 4'($urandom);
			p = {4'($urandom), lane_pairs};
		end else begin
			p = 8'($urandom);
			if (r < 82)
				m = MODE_READ;
			else if (r < 93)
				m = MODE_SET;
			else
				m = MODE_CLEAR;
		end
		send_word(m, p, ix, np);
	endtask

	// Hand-picked walks, reads, limits and invalid indexes
	task automatic test_directed();
		write_reg(CFG_ENC_COUNT, 4'd4);
		write_reg(CFG_LATCH_MODE, 4'(LATCH_AT3));
		write_reg(CFG_BUTTON0, 4'd7);
		write_reg(CFG_BUTTON1, 4'd4);
		settings_run++;
		// lane 0 turns clockwise, lane 1 counterclockwise, one full detent
		sample_port(8'hFF);
		sample_port(8'h09);
		sample_port(8'h80);
		sample_port(8'h16);
		sample_port(8'hEF);
		read_position(3'd0);
		read_position(3'd1);
		read_position(3'd1);
		read_position(3'd2);
		read_position(3'd7);
		// load the largest position and step past the wrap
		send_word(MODE_SET, 8'hFF, 3'd0, 32'sh7FFF_FFFF);
		read_position(3'd0);
		sample_port(8'hFD);
		sample_port(8'hFC);
		sample_port(8'hFE);
		sample_port(8'hFF);
		read_position(3'd0);
		send_word(MODE_SET, 8'h00, 3'd1, 32'sh8000_0000);
		read_position(3'd1);
		send_word(MODE_CLEAR, 8'h00, 3'd0, '0);
		read_position(3'd0);
		// illegal jump 3 -> 0 on both lanes, then invalid index on load and clear
		sample_port(8'hF0);
		send_word(MODE_SET, 8'h00, 3'd5, 32'sh1234_5678);
		send_word(MODE_CLEAR, 8'h00, 3'd6, '0);
		lane_pairs = 4'h0;
		drain_results();
	endtask

	// Random traffic under a series of register settings, extremes included
	task automatic test_register_sweep();
		logic [3:0] counts  [8] = '{4'd4, 4'd1, 4'd2, 4'd0, 4'd7, 4'd3, 4'd4, 4'd2};
		latch_t     latches [8] = '{LATCH_AT3, LATCH_AT0, LATCH_TWO, LATCH_AT3,
			LATCH_NONE, LATCH_TWO, LATCH_AT0, LATCH_AT3};
		logic [3:0] b0_bits [8] = '{4'd7, 4'd0, 4'd3, 4'd8, 4'd5, 4'd15, 4'd1, 4'd6};
		logic [3:0] b1_bits [8] = '{4'd4, 4'd8, 4'd15, 4'd0, 4'd6, 4'd7, 4'd2, 4'd3};
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			write_reg(CFG_ENC_COUNT, counts[ph]);
			write_reg(CFG_LATCH_MODE, 4'(latches[ph]));
			write_reg(CFG_BUTTON0, b0_bits[ph]);
			write_reg(CFG_BUTTON1, b1_bits[ph]);
			settings_run++;
			// one phase runs back to back with no idling on either side
			tx_gap_max   = (ph == 5) ? 0 : 7;
			rx_stall_max = (ph == 5) ? 0 : 7;
			for (int k = 0; k < PHASE_WORDS; k++)
				send_random_word();
		end
		tx_gap_max   = 7;
		rx_stall_max = 7;
		drain_results();
	endtask

	// Receiver holds off long while the sender keeps offering, so in_ready must drop
	task automatic test_backpressure();
		tx_gap_max  = 0;
		rx_hold_req = 150;
		for (int k = 0; k < 40; k++)
			send_random_word();
		tx_gap_max = 7;
		drain_results();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		mode           = MODE_SAMPLE;
		port_sample    = 8'h00;
		encoder_index  = 3'd0;
		new_position   = '0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_ENC_COUNT;
		cfg_data       = '0;
		lane_pairs     = 4'hF;
		tx_gap_max     = 7;
		rx_stall_max   = 7;
		rx_hold_req    = 0;
		words_sent     = 0;
		words_checked  = 0;
		rotation_reads = 0;
		settings_run   = 0;
		errors         = 0;
		cycle_count    = 0;
		reset_shadow();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_sweep();
		test_backpressure();

		// catch any stray word after the last expected one
		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d words under %0d register settings, %0d results checked",
			words_sent, settings_run, words_checked);
		$display("%0d position reads reported rotation, %0d mismatches", rotation_reads, errors);
		if (errors == 0 && expected_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/mqd_pkg.sv
hw/rtl/mqd_lane.sv
hw/rtl/mqd_outbuf.sv
hw/rtl/multi_quadrature_decoder.sv
hw/rtl/mqd_chk.sv
tb/testbench.sv
